@@ design/elcu_pkg.sv @@
package elcu_pkg;

  localparam int unsigned YawFull = 46080;
  localparam int signed PitchMax = 11392;
  localparam int signed OneQ14 = 16384;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [31:0] HomeX = 32'sd0;
  localparam logic signed [31:0] HomeY = 32'sd262144;
  localparam logic signed [31:0] HomeZ = 32'sd1179648;
  localparam logic [15:0] HomeYaw = 16'd34560;
  localparam logic signed [15:0] HomePitch = -16'sd640;

  typedef enum logic [1:0] {
    KIND_MOUSE = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_HOME  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    DIR_FWD   = 3'd0,
    DIR_BACK  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_UP    = 3'd4,
    DIR_DOWN  = 3'd5
  } dir_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOUSE,
    ST_WRAP,
    ST_TRIG_START,
    ST_TRIG_RUN,
    ST_MUL_START,
    ST_MUL_RUN,
    ST_MOVE_MUL,
    ST_MOVE_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    REG_MOVE_SPEED = 2'd0,
    REG_MOUSE_SENS = 2'd1
  } reg_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0: atan_q16 = 22'd2949120;
      5'd1: atan_q16 = 22'd1740967;
      5'd2: atan_q16 = 22'd919879;
      5'd3: atan_q16 = 22'd466945;
      5'd4: atan_q16 = 22'd234379;
      5'd5: atan_q16 = 22'd117304;
      5'd6: atan_q16 = 22'd58666;
      5'd7: atan_q16 = 22'd29335;
      5'd8: atan_q16 = 22'd14668;
      5'd9: atan_q16 = 22'd7334;
      5'd10: atan_q16 = 22'd3667;
      5'd11: atan_q16 = 22'd1833;
      5'd12: atan_q16 = 22'd917;
      5'd13: atan_q16 = 22'd458;
      5'd14: atan_q16 = 22'd229;
      5'd15: atan_q16 = 22'd115;
      5'd16: atan_q16 = 22'd57;
      5'd17: atan_q16 = 22'd29;
      5'd18: atan_q16 = 22'd14;
      5'd19: atan_q16 = 22'd7;
      5'd20: atan_q16 = 22'd4;
      5'd21: atan_q16 = 22'd2;
      5'd22: atan_q16 = 22'd1;
      default: atan_q16 = 22'd0;
    endcase
  endfunction

  function automatic logic signed [15:0] clamp_unit(input logic signed [47:0] v);
    if (v > 48'sd16384) clamp_unit = 16'sd16384;
    else if (v < -48'sd16384) clamp_unit = -16'sd16384;
    else clamp_unit = v[15:0];
  endfunction

endpackage

@@ design/elcu_if.sv @@
interface elcu_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  logic signed [15:0] mouse_x;
  logic signed [15:0] mouse_y;
  logic [2:0] move_dir;
  logic [15:0] step_time;
  modport source (output valid, kind, mouse_x, mouse_y, move_dir, step_time, input ready);
  modport sink (input valid, kind, mouse_x, mouse_y, move_dir, step_time, output ready);
endinterface

interface elcu_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_y;
  logic signed [15:0] front_z;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  modport source (output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                  right_x, right_y, right_z, up_x, up_y, up_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
                right_x, right_y, right_z, up_x, up_y, up_z, output ready);
endinterface

@@ design/elcu_serial_mul.sv @@
module elcu_serial_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic                      done,
  output logic signed [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);

  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0] mplier;
  logic [CW-1:0] cnt;
  logic busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // radix-2 shift and add, top bit of multiplier has negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      mcand <= (AW+BW)'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        if (cnt == CW'(BW - 1)) acc <= acc - mcand;
        else acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign prod = acc;
endmodule

@@ design/euler_look_camera_update_core.sv @@
// work per item: a move item runs three products on the shared multiplier; a mouse
// item runs two products, the yaw wrap, two cordic rotations and four products; a home
// item runs the two rotations and four products; a first mouse item, a move with an
// unknown direction and any other item go straight to the result
// throughput: one item at a time, through one 34 bit shift-add multiplier and one cordic
// reset: synchronous, active high; a home rebuild runs first and ready rises when it ends
module euler_look_camera_update_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  elcu_in_if.sink     in_ch,
  elcu_out_if.source  out_ch
);
  import elcu_pkg::*;

  localparam int SW = $clog2(CORDIC_STEPS + 1);

  state_t state, state_next;

  logic [15:0] move_speed, mouse_sens;
  logic signed [31:0] pos [3];
  logic [15:0] yaw;
  logic signed [15:0] pitch;
  logic signed [15:0] last_x, last_y;
  logic first_event;
  logic signed [15:0] basis [9];

  logic [2:0] dir;
  logic signed [15:0] mx, my;
  logic home_pend;

  // cordic
  logic signed [33:0] cx, cy;
  logic signed [23:0] cz;
  logic [SW-1:0] step;
  logic flip;
  logic which;
  logic signed [33:0] sy, cyw, sp, cp;

  // multiplier sequencing
  logic [1:0] sel;
  logic mstart, mstart_next, mdone;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mprod;
  logic signed [33:0] dx, dy;
  logic [31:0] move_len;

  // yaw reduction
  logic [24:0] yacc, yacc_next;
  logic [23:0] ymod;
  logic [3:0] wcnt;

  elcu_serial_mul #(.AW(34), .BW(34)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      move_speed <= 16'd2048;
      mouse_sens <= 16'd9830;
    end else if (cfg_we) begin
      case (cfg_index)
        1'(REG_MOVE_SPEED): move_speed <= cfg_data;
        default: mouse_sens <= cfg_data;
      endcase
    end
  end

  assign in_ch.ready = (state == ST_IDLE) && !home_pend;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (home_pend) state_next = ST_TRIG_START;
        else if (in_ch.valid) begin
          case (in_ch.kind)
            KIND_MOUSE: state_next = first_event ? ST_DONE : ST_MOUSE;
            KIND_MOVE: state_next = (in_ch.move_dir > 3'd5) ? ST_DONE : ST_MOVE_MUL;
            KIND_HOME: state_next = ST_TRIG_START;
            default: state_next = ST_DONE;
          endcase
        end
      ST_MOUSE: if (mdone && sel == 2'd1) state_next = ST_WRAP;
      ST_WRAP: if (wcnt == 4'd8) state_next = ST_TRIG_START;
      ST_TRIG_START: state_next = ST_TRIG_RUN;
      ST_TRIG_RUN:
        if (step == SW'(CORDIC_STEPS)) state_next = which ? ST_MUL_START : ST_TRIG_START;
      ST_MUL_START: state_next = ST_MUL_RUN;
      ST_MUL_RUN:
        if (mdone) state_next = (sel == 2'd3) ? (home_pend ? ST_IDLE : ST_DONE) : ST_MUL_START;
      ST_MOVE_MUL: state_next = ST_MOVE_RUN;
      ST_MOVE_RUN: if (mdone && sel == 2'd2) state_next = ST_DONE;
      ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign out_ch.valid = (state == ST_DONE);

  always_comb begin
    mstart_next = 1'b0;
    case (state)
      ST_IDLE:
        mstart_next = !home_pend && in_ch.valid && (in_ch.kind == KIND_MOUSE)
                      && !first_event;
      ST_MOUSE: mstart_next = mdone && (sel == 2'd0);
      ST_MUL_START, ST_MOVE_MUL: mstart_next = 1'b1;
      ST_MOVE_RUN: mstart_next = mdone && (sel != 2'd2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) mstart <= 1'b0;
    else mstart <= mstart_next;
  end

  // operand select for shared multiplier
  logic signed [15:0] mvec [3];
  logic msign;
  always_comb begin
    mvec[0] = 16'sd0; mvec[1] = 16'sd16384; mvec[2] = 16'sd0;
    msign = dir[0];
    case (dir)
      DIR_FWD, DIR_BACK: begin
        mvec[0] = basis[0]; mvec[1] = basis[1]; mvec[2] = basis[2];
      end
      DIR_LEFT, DIR_RIGHT: begin
        mvec[0] = basis[3]; mvec[1] = basis[4]; mvec[2] = basis[5];
        msign = ~dir[0];
      end
      default: ;
    endcase
    ma = '0; mb = '0;
    case (state)
      ST_MOUSE: begin
        ma = sel[0] ? 34'(signed'(17'(last_y) - 17'(my)))
                    : 34'(signed'(17'(mx) - 17'(last_x)));
        mb = 34'(signed'({1'b0, mouse_sens}));
      end
      ST_MUL_START, ST_MUL_RUN: begin
        ma = sel[0] ? sy : cyw;
        mb = sel[1] ? sp : cp;
      end
      ST_MOVE_RUN, ST_MOVE_MUL: begin
        ma = msign ? -$signed({2'b00, move_len}) : $signed({2'b00, move_len});
        mb = 34'(mvec[sel]);
      end
      default: ;
    endcase
  end

  logic signed [67:0] rq60;
  logic signed [15:0] q60;
  logic signed [47:0] step_q16;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  assign rq60 = mprod + (68'sd1 <<< 45);
  assign q60 = clamp_unit(48'(rq60 >>> 46));
  assign step_q16 = 48'((mprod + 68'sd2097152) >>> 22);
  always_comb begin
    psum = 34'(pos[sel]) + 34'(step_q16);
    if (step_q16 > 48'sh7fffffff || psum > 34'sh7fffffff) psat = 32'sh7fffffff;
    else if (step_q16 < -48'sh80000000 || psum < -34'sh80000000) psat = -32'sh80000000;
    else psat = psum[31:0];
  end

  function automatic logic signed [15:0] q30(input logic signed [33:0] v);
    q30 = clamp_unit(48'((v + 34'sd32768) >>> 16));
  endfunction

  // cordic start values, folded in degrees q9.7 before the shift to q.16
  logic signed [16:0] ain;
  logic signed [16:0] af;
  logic signed [23:0] zf;
  logic fl;
  always_comb begin
    ain = which ? 17'(pitch) : $signed({1'b0, yaw});
    af = ain;
    fl = 1'b0;
    if (af >= 17'sd23040) af = af - 17'sd46080;
    if (af > 17'sd11520) begin af = af - 17'sd23040; fl = 1'b1; end
    else if (af < -17'sd11520) begin af = af + 17'sd23040; fl = 1'b1; end
    zf = 24'(af) <<< 9;
  end

  logic signed [33:0] xs, ys;
  logic signed [23:0] at;
  assign xs = cx >>> step;
  assign ys = cy >>> step;
  assign at = 24'(atan_q16(5'(step)));

  logic signed [24:0] ddx, ddy;
  logic signed [25:0] ysum;
  logic signed [25:0] tp;
  assign ddx = 25'((dx + 34'sd256) >>> 9);
  assign ddy = 25'((dy + 34'sd256) >>> 9);
  assign ysum = $signed({10'd0, yaw}) + 26'(ddx);
  assign tp = 26'(pitch) + 26'(ddy);
  assign yacc_next = (yacc >= {1'b0, ymod}) ? yacc - {1'b0, ymod} : yacc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= HomeX; pos[1] <= HomeY; pos[2] <= HomeZ;
      yaw <= HomeYaw; pitch <= HomePitch;
      last_x <= '0; last_y <= '0;
      first_event <= 1'b1;
      home_pend <= 1'b1;
      which <= 1'b0;
      sel <= '0;
      step <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          which <= 1'b0;
          sel <= '0;
          if (home_pend) begin
            // rebuild only
          end else if (in_ch.valid) begin
            dir <= in_ch.move_dir;
            mx <= in_ch.mouse_x; my <= in_ch.mouse_y;
            case (in_ch.kind)
              KIND_MOUSE: begin
                if (first_event) begin
                  first_event <= 1'b0;
                  last_x <= in_ch.mouse_x; last_y <= in_ch.mouse_y;
                end
              end
              KIND_MOVE: move_len <= 32'(move_speed) * 32'(in_ch.step_time);
              KIND_HOME: begin
                pos[0] <= HomeX; pos[1] <= HomeY; pos[2] <= HomeZ;
                yaw <= HomeYaw; pitch <= HomePitch; first_event <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        ST_MOUSE: begin
          if (mdone) begin
            if (sel == 2'd0) begin
              dx <= mprod[33:0]; sel <= 2'd1;
            end else begin
              dy <= mprod[33:0]; sel <= 2'd0;
              yacc <= ysum[25] ? 25'(ysum + 26'sd11796480) : ysum[24:0];
              ymod <= 24'd11796480;
              wcnt <= '0;
            end
          end
        end
        ST_WRAP: begin
          // modulo 360 degrees by compare and subtract of shifted multiples
          yacc <= yacc_next;
          ymod <= ymod >> 1;
          wcnt <= wcnt + 1'b1;
          if (wcnt == 4'd8) begin
            last_x <= mx; last_y <= my;
            yaw <= yacc_next[15:0];
            if (tp > 26'sd11392) pitch <= 16'sd11392;
            else if (tp < -26'sd11392) pitch <= -16'sd11392;
            else pitch <= tp[15:0];
          end
        end
        ST_TRIG_START: begin
          cx <= CordicK; cy <= '0; cz <= zf; flip <= fl; step <= '0;
        end
        ST_TRIG_RUN: begin
          if (step == SW'(CORDIC_STEPS)) begin
            if (!which) begin
              sy <= flip ? -cy : cy; cyw <= flip ? -cx : cx; which <= 1'b1;
            end else begin
              sp <= flip ? -cy : cy; cp <= flip ? -cx : cx; sel <= '0;
            end
          end else begin
            step <= step + 1'b1;
            if (cz >= 0) begin cx <= cx - ys; cy <= cy + xs; cz <= cz - at; end
            else begin cx <= cx + ys; cy <= cy - xs; cz <= cz + at; end
          end
        end
        ST_MUL_RUN: begin
          if (mdone) begin
            case (sel)
              2'd0: basis[0] <= q60;
              2'd1: basis[2] <= q60;
              2'd2: basis[6] <= clamp_unit(48'((68'sd35184372088832 - mprod) >>> 46));
              default: begin
                basis[8] <= clamp_unit(48'((68'sd35184372088832 - mprod) >>> 46));
                basis[1] <= q30(sp); basis[3] <= q30(-sy); basis[4] <= '0;
                basis[5] <= q30(cyw); basis[7] <= q30(cp);
                home_pend <= 1'b0;
              end
            endcase
            sel <= sel + 1'b1;
          end
        end
        ST_MOVE_MUL: sel <= '0;
        ST_MOVE_RUN: begin
          if (mdone) begin
            pos[sel] <= psat;
            sel <= sel + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.pos_x = pos[0];
  assign out_ch.pos_y = pos[1];
  assign out_ch.pos_z = pos[2];
  assign out_ch.front_x = basis[0];
  assign out_ch.front_y = basis[1];
  assign out_ch.front_z = basis[2];
  assign out_ch.right_x = basis[3];
  assign out_ch.right_y = basis[4];
  assign out_ch.right_z = basis[5];
  assign out_ch.up_x = basis[6];
  assign out_ch.up_y = basis[7];
  assign out_ch.up_z = basis[8];

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == ST_IDLE) else $error("ready outside idle");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    pitch <= 16'sd11392 && pitch >= -16'sd11392) else $error("pitch out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    yaw < 16'd46080) else $error("yaw out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(pos[0]))
    else $error("result lost");
`endif
endmodule
